@@ src/assert_macros.svh @@
// assertion macros for the allocator rtl
// expects aclk and aresetn in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every aclk edge outside reset
`define ASSERT_ACLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// expression must never be true at an aclk edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

@@ src/bra_pkg.sv @@
// types and constants for the bitmap run allocator
// no dependencies; imported by every allocator module
package bra_pkg;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_FIND  = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_e;

    localparam logic [9:0] BYTES_IN_USE_RESET = 10'd512;

    typedef struct packed {
        cmd_e        cmd;
        logic [11:0] bit_index;
        logic        bit_value;
        logic [12:0] run_length;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] start_index;
        logic        bit_is_set;
        logic        index_error;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic check;
        logic addr_clr;
        logic scan_step;
        logic idx_read;
        logic bit_op;
        logic sweep_step;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_e cmd;
        logic err;
        logic scan_done;
        logic sweep_last;
    } dp_stat_t;

endpackage

@@ src/bra_ctrl.sv @@
// sequencing state machine of the bitmap run allocator
// depends on bra_pkg and assert_macros.svh
`include "assert_macros.svh"

module bra_ctrl
    import bra_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dp_stat_t  stat_i,
    output ctrl_cmd_t cmd_o
);

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_READ  = 8'b0001_0000,
        ST_BITOP = 8'b0010_0000,
        ST_CLEAR = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd_o        = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_INIT: begin
                cmd_o.sweep_step = 1'b1;
                if (stat_i.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.item_load = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd_o.check = 1'b1;
                if (stat_i.err) begin
                    state_next = ST_DONE;
                end else begin
                    case (stat_i.cmd)
                        CMD_FIND: begin
                            cmd_o.addr_clr = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        CMD_TEST, CMD_WRITE: begin
                            state_next = ST_READ;
                        end
                        CMD_CLEAR: begin
                            cmd_o.addr_clr = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd_o.scan_step = 1'b1;
                if (stat_i.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd_o.idx_read = 1'b1;
                state_next     = ST_BITOP;
            end
            ST_BITOP: begin
                cmd_o.bit_op = 1'b1;
                state_next   = ST_DONE;
            end
            ST_CLEAR: begin
                cmd_o.sweep_step = 1'b1;
                if (stat_i.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd_o.out_load = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_ACLK(a_accept_decodes, s_valid && s_ready |=> state_reg == ST_CHECK, "word not decoded")
    `ASSERT_NEVER(a_no_overwrite, cmd_o.out_load && m_valid_reg && !m_ready, "pending result lost")
    `ASSERT_ACLK(a_scan_holds, state_reg == ST_SCAN && !stat_i.scan_done |=> state_reg == ST_SCAN, "scan left early")

endmodule

@@ src/bra_dp.sv @@
// datapath of the bitmap run allocator: bitmap store, scan and result registers
// depends on bra_pkg
module bra_dp
    import bra_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 512
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  logic [9:0] eff_bytes,
    input  ctrl_cmd_t  cmd_i,
    output dp_stat_t   stat_o,
    output out_item_t  m_data
);

    localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    logic [7:0]    mem [MAX_BYTES];
    in_item_t      item_reg;
    logic [AW-1:0] addr_reg;
    logic          issue_done_reg;
    logic          rd_pending_reg;
    logic [12:0]   run_reg;
    logic [12:0]   base_reg;
    logic [7:0]    rdata_reg;
    out_item_t     res_reg;
    out_item_t     out_reg;

    logic [12:0]   total_bits;
    logic          err;
    logic [AW-1:0] bit_byte_addr;
    logic          addr_last;
    logic          issue;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    set_byte;
    logic [12:0]   run_next;
    logic          hit;
    logic [12:0]   hit_pos;

    assign total_bits    = {eff_bytes, 3'b000};
    assign bit_byte_addr = AW'(item_reg.bit_index >> 3);
    assign addr_last     = 32'(addr_reg) == 32'(eff_bytes) - 32'd1;
    assign issue         = cmd_i.scan_step && !issue_done_reg;

    always_comb begin
        case (item_reg.cmd)
            CMD_FIND:  err = (item_reg.run_length == 13'd0) ||
                             (item_reg.run_length > total_bits);
            CMD_TEST,
            CMD_WRITE: err = {1'b0, item_reg.bit_index} >= total_bits;
            default:   err = 1'b0;
        endcase
    end

    // one byte of the scan: run of free bits carried across bytes
    always_comb begin
        run_next = run_reg;
        hit      = 1'b0;
        hit_pos  = '0;
        for (int b = 0; b < 8; b++) begin
            if (!hit) begin
                if (rdata_reg[b]) begin
                    run_next = '0;
                end else begin
                    run_next = run_next + 13'd1;
                    if (run_next == item_reg.run_length) begin
                        hit     = 1'b1;
                        hit_pos = base_reg + 13'(b) + 13'd1 - item_reg.run_length;
                    end
                end
            end
        end
    end

    always_comb begin
        set_byte                          = rdata_reg;
        set_byte[item_reg.bit_index[2:0]] = item_reg.bit_value;
    end

    assign rd_en   = cmd_i.idx_read || issue;
    assign rd_addr = cmd_i.idx_read ? bit_byte_addr : addr_reg;
    assign wr_en   = cmd_i.sweep_step || (cmd_i.bit_op && item_reg.cmd == CMD_WRITE);
    assign wr_addr = cmd_i.sweep_step ? addr_reg : bit_byte_addr;
    assign wr_data = cmd_i.sweep_step ? 8'h00 : set_byte;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // scan control and sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else if (cmd_i.addr_clr) begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            if (cmd_i.sweep_step || issue) begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (issue) begin
                issue_done_reg <= addr_last;
            end
            if (cmd_i.scan_step) begin
                rd_pending_reg <= !issue_done_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.item_load) begin
            item_reg <= s_data;
        end
        if (cmd_i.addr_clr) begin
            run_reg  <= '0;
            base_reg <= '0;
        end else if (cmd_i.scan_step && rd_pending_reg) begin
            run_reg  <= run_next;
            base_reg <= base_reg + 13'd8;
        end
        if (cmd_i.check) begin
            res_reg             <= '0;
            res_reg.index_error <= err;
        end else if (cmd_i.scan_step && rd_pending_reg && hit) begin
            res_reg.found       <= 1'b1;
            res_reg.start_index <= hit_pos[11:0];
        end else if (cmd_i.bit_op && item_reg.cmd == CMD_TEST) begin
            res_reg.bit_is_set  <= rdata_reg[item_reg.bit_index[2:0]];
        end
        if (cmd_i.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat_o.cmd        = item_reg.cmd;
    assign stat_o.err        = err;
    assign stat_o.scan_done  = rd_pending_reg && (hit || issue_done_reg);
    assign stat_o.sweep_last = addr_reg == AW'(MAX_BYTES - 1);
    assign m_data            = out_reg;

endmodule

@@ src/bitmap_run_allocator_top.sv @@
// top level of the bitmap run allocator: byte-count register, controller and datapath
// depends on bra_pkg, bra_ctrl and bra_dp
//
// First-fit bitmap allocator. Words are taken one at a time; each gives exactly one
// result word, held in an output register so the next word is accepted while it waits.
// Timing is set by the single byte-wide read port of the bitmap store: a find reads one
// byte per cycle over eff_bytes bytes when nothing is found (eff_bytes is bytes_in_use
// held to 1..min(MAX_BYTES, 1023)) and stops early when a run turns up. Test and write
// read the byte, then modify or select; errors go straight to the result. Clear zeroes
// all MAX_BYTES bytes, one byte per cycle. The same sweep zeroes the store after reset
// and s_ready stays low until it ends; the byte-count register can be written meanwhile.
module bitmap_run_allocator_top
    import bra_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 512
) (
    input  logic       aclk,
    input  logic       aresetn,
    // byte-count register, to be written only while idle; the block does not enforce this
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    // command words
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    // the byte count never usefully exceeds the store or the register range
    localparam int unsigned EFF_CAP = (MAX_BYTES > 1023) ? 1023 : MAX_BYTES;

    logic [9:0] bytes_in_use_reg;
    logic [9:0] eff_bytes;
    ctrl_cmd_t  cmd;
    dp_stat_t   stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_in_use_reg <= BYTES_IN_USE_RESET;
        end else if (cfg_wr_en) begin
            bytes_in_use_reg <= cfg_wr_data;
        end
    end

    // zero acts as one byte, anything past the store as the whole store
    always_comb begin
        if (bytes_in_use_reg == 10'd0) begin
            eff_bytes = 10'd1;
        end else if (bytes_in_use_reg > 10'(EFF_CAP)) begin
            eff_bytes = 10'(EFF_CAP);
        end else begin
            eff_bytes = bytes_in_use_reg;
        end
    end

    bra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat_i  (stat),
        .cmd_o   (cmd)
    );

    bra_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .eff_bytes (eff_bytes),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .m_data    (m_data)
    );

endmodule
